// ----- rtl/insertion_sorter_assert.svh -----
// Assertion macros for the insertion sorter RTL, used by its controller.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISORT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISORT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/isort_pkg.sv -----
// Shared types and constants of the insertion sorter.
package isort_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] word_t;

    // Per-cycle commands from the controller to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } ctl_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

endpackage

// ----- rtl/isort_cell.sv -----
// One cell of the insertion chain: holds one stored word.
module isort_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                aclk,
    input  isort_pkg::ctl_t     ctl,
    input  logic [CNT_W-1:0]    count,
    input  isort_pkg::word_t    new_value,
    input  isort_pkg::word_t    below_value,
    input  logic                below_gt,
    input  isort_pkg::word_t    above_value,
    output isort_pkg::word_t    value,
    output logic                gt
);

    isort_pkg::word_t value_reg;
    isort_pkg::word_t value_next;
    logic             occupied;
    logic             at_fill;

    assign occupied = (count > CNT_W'(IDX));
    assign at_fill  = (count == CNT_W'(IDX));
    assign gt       = occupied && (value_reg > new_value);

    always_comb begin
        value_next = value_reg;
        if (ctl.insert && (gt || at_fill)) begin
            // take the neighbor's word if it moves up too, else the new word
            value_next = below_gt ? below_value : new_value;
        end else if (ctl.shift) begin
            value_next = above_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- rtl/isort_ctrl.sv -----
// Fill/drain controller of the insertion sorter: count, overflow and handshakes.
`include "insertion_sorter_assert.svh"

module isort_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                run_end,
    output logic                overflowed,
    output isort_pkg::ctl_t     ctl,
    output logic [CNT_W-1:0]    count
);

    isort_pkg::state_t state_reg;
    isort_pkg::state_t state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic              full;
    logic              out_word;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign out_word = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= isort_pkg::ST_FILL;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        ctl.insert   = 1'b0;
        ctl.shift    = 1'b0;
        case (state_reg)
            isort_pkg::ST_FILL: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        ctl.insert = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        state_next = isort_pkg::ST_DRAIN;
                    end
                end
            end
            isort_pkg::ST_DRAIN: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    // advance the chain toward cell 0
                    ctl.shift  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        state_next   = isort_pkg::ST_FILL;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = isort_pkg::ST_FILL;
            end
        endcase
    end

    assign run_end    = (count_reg == CNT_W'(1));
    assign overflowed = dropped_reg;
    assign count      = count_reg;

    `ISORT_ASSERT_NOW(a_count_in_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY), "fill count past capacity")
    `ISORT_ASSERT_NOW(a_drain_not_empty, aclk, aresetn, m_tvalid, count_reg != '0, "drain with empty store")
    `ISORT_ASSERT_NOW(a_sides_exclusive, aclk, aresetn, s_tready, !m_tvalid, "fill and drain at once")
    `ISORT_ASSERT_NEXT(a_batch_closed, aclk, aresetn, out_word && run_end, (count_reg == '0) && !dropped_reg && s_tready, "batch not closed after last word")

endmodule

// ----- rtl/insertion_sorter.sv -----
// Insertion sorter top level: controller plus a chain of storage cells.
// Accepts one signed 32-bit word per cycle while filling; every cell compares
// its word with the incoming one in parallel, so insertion does not depend on
// position. The word with tlast closes the batch: the sorted store is then
// sent out lowest first, one word per cycle while m_tready is high, and
// s_tready stays low meanwhile. Draining starts straight after the batch closes,
// and filling resumes straight after the last word of the batch has gone out.
// Words beyond CAPACITY are dropped and every output word of that batch then
// carries m_tuser = 1. m_tlast marks the largest word.
module insertion_sorter #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic        m_tuser    // [0] overflowed
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    isort_pkg::ctl_t  ctl;
    logic [CNT_W-1:0] count;
    isort_pkg::word_t new_value;
    isort_pkg::word_t cell_value [CAPACITY];
    logic             cell_gt    [CAPACITY];

    assign new_value = isort_pkg::word_t'(s_tdata);

    isort_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .run_end    (m_tlast),
        .overflowed (m_tuser),
        .ctl        (ctl),
        .count      (count)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        isort_pkg::word_t below_value;
        logic             below_gt;
        isort_pkg::word_t above_value;

        if (i == 0) begin : g_first
            assign below_value = new_value;
            assign below_gt    = 1'b0;
        end else begin : g_inner
            assign below_value = cell_value[i-1];
            assign below_gt    = cell_gt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_top
            assign above_value = cell_value[i];
        end else begin : g_mid
            assign above_value = cell_value[i+1];
        end

        isort_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .count       (count),
            .new_value   (new_value),
            .below_value (below_value),
            .below_gt    (below_gt),
            .above_value (above_value),
            .value       (cell_value[i]),
            .gt          (cell_gt[i])
        );
    end

    assign m_tdata = 32'(cell_value[0]);

endmodule
